FILE: hw/rtl/grbp_pkg.sv
// Shared types, register codes and the byte finishing function for the glyph row bit packer.
// No dependencies; imported by every module of the block.
package grbp_pkg;

  localparam int PIX_W   = 8;  // pixel_color width
  localparam int BYTE_W  = 8;  // prom_byte width
  localparam int COL_W   = 6;  // column counter width (wraps at 64)
  localparam int ROW_W   = 5;  // row counter width (wraps at 32)
  localparam int CIDX_W  = 3;  // config register index width
  localparam int CDATA_W = 8;  // config write data width
  localparam int MAX_HEIGHT = 32;

  // Config register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_DOT_COLOR       = 3'd0,
    REG_GLYPH_WIDTH     = 3'd1,
    REG_GLYPH_HEIGHT    = 3'd2,
    REG_KEPT_BITS       = 3'd3,
    REG_BYTES_PER_GLYPH = 3'd4,
    REG_NEGATE          = 3'd5,
    REG_LEFT_ALIGN      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] dot_color;
    logic [6:0] glyph_width;
    logic [5:0] glyph_height;
    logic [3:0] kept_bits;
    logic [5:0] bytes_per_glyph;
    logic       negate;
    logic       left_align;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dot_color:       8'd1,
    glyph_width:     7'd8,
    glyph_height:    6'd8,
    kept_bits:       4'd8,
    bytes_per_glyph: 6'd16,
    negate:          1'b0,
    left_align:      1'b0
  };

  // Row result handed from the packer to the output stage
  typedef struct packed {
    logic              valid;  // a row ended on this beat
    logic [BYTE_W-1:0] data;   // finished row byte
    logic              last;   // row byte closes the glyph (no padding)
    logic [5:0]        pad;    // padding bytes to follow
  } row_res_t;

  // Invert, mask to the kept bits, optionally align to bit 7
  function automatic logic [BYTE_W-1:0] finish_byte(logic [BYTE_W-1:0] bits, cfg_t c);
    logic [3:0]        k;
    logic [BYTE_W:0]   m;
    logic [BYTE_W-1:0] v;
    k = (c.kept_bits > 4'd8) ? 4'd8 : c.kept_bits;
    m = ({{BYTE_W{1'b0}}, 1'b1} << k) - {{BYTE_W{1'b0}}, 1'b1};
    v = (c.negate ? ~bits : bits) & m[BYTE_W-1:0];
    if (c.left_align) begin
      v = v << (4'd8 - k);
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/glyph_row_bit_packer.sv
// Glyph row bit packer: pixel stream in, packed glyph row bytes out.
//
// Usage:
//  - in_*: one pixel color index per beat, in raster order.
//  - out_*: one byte per beat; tuser marks padding bytes, tlast the glyph's
//    final byte. A row byte appears when a row's last pixel is taken; after a
//    glyph's last row the padding bytes follow back to back.
//  - cfg_*: register writes, always ready; write only while the block is idle.
// A row byte enters the output register, or the skid slot in a stall, when the row's
// last pixel beat is taken. Throughput: one pixel per cycle while in_tready is high.
// The padding sequencer feeds the output register one byte per cycle while out_tready
// is high; in_tready is low while a glyph's bytes_per_glyph - glyph_height pads are owed.
// Stall: a two-entry output (register plus skid slot) keeps pixels flowing
// while the receiver stalls; in_tready drops once the skid slot holds a byte.
// Reset (rst_n low, synchronous): counters, row register and output cleared,
// registers back to their defaults. No clearing pass is needed.
// Depends on grbp_pkg, grbp_row and grbp_out.
module glyph_row_bit_packer
  import grbp_pkg::*;
#(
  parameter int COLOR_BITS = 8,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_BYTES  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // pixel stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [PIX_W-1:0]   in_tdata,   // [7:0] pixel_color
  // byte stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [BYTE_W-1:0]  out_tdata,  // [7:0] prom_byte
  output logic               out_tuser,  // [0] is_padding
  output logic               out_tlast,  // glyph_last
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  row_res_t res;
  logic     take_ok;
  logic     pix_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = take_ok;
  assign pix_fire  = in_tvalid && take_ok;

  // Register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DOT_COLOR:       cfg_nxt.dot_color       = cfg_data;
        REG_GLYPH_WIDTH:     cfg_nxt.glyph_width     = cfg_data[6:0];
        REG_GLYPH_HEIGHT:    cfg_nxt.glyph_height    = cfg_data[5:0];
        REG_KEPT_BITS:       cfg_nxt.kept_bits       = cfg_data[3:0];
        REG_BYTES_PER_GLYPH: cfg_nxt.bytes_per_glyph = cfg_data[5:0];
        REG_NEGATE:          cfg_nxt.negate          = cfg_data[0];
        REG_LEFT_ALIGN:      cfg_nxt.left_align      = cfg_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  grbp_row #(
    .COLOR_BITS (COLOR_BITS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_BYTES  (MAX_BYTES)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pix_fire  (pix_fire),
    .pix_color (in_tdata),
    .res       (res)
  );

  grbp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .res        (res),
    .take_ok    (take_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/grbp_row.sv
// Dot compare, row shift register and column/row counters of the glyph row bit packer.
// Depends on grbp_pkg; flags a valid row_res_t when an accepted pixel beat ends a row.
module grbp_row
  import grbp_pkg::*;
#(
  parameter int COLOR_BITS = 8,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_BYTES  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             pix_fire,
  input  logic [PIX_W-1:0] pix_color,
  output row_res_t         res
);

  localparam int CMP_BITS = (COLOR_BITS < PIX_W) ? COLOR_BITS : PIX_W;
  localparam int WCAP     = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int NBCAP    = (MAX_BYTES < 63) ? MAX_BYTES : 63;

  logic [COL_W-1:0]  column_r, column_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;

  logic [6:0]        w_eff;
  logic [5:0]        h_eff, nb_eff;
  logic              dot;
  logic [BYTE_W-1:0] shift_new;
  logic [COL_W-1:0]  col_new;
  logic [ROW_W-1:0]  row_new;
  logic              row_end, glyph_end;
  logic [5:0]        pad_cnt;

  // Effective limits with out-of-range values clamped
  always_comb begin
    w_eff  = (cfg.glyph_width == 7'd0) ? 7'd1 : cfg.glyph_width;
    if (w_eff > 7'(WCAP)) begin
      w_eff = 7'(WCAP);
    end
    h_eff  = (cfg.glyph_height == 6'd0) ? 6'd1 : cfg.glyph_height;
    if (h_eff > 6'(MAX_HEIGHT)) begin
      h_eff = 6'(MAX_HEIGHT);
    end
    nb_eff = (cfg.bytes_per_glyph > 6'(NBCAP)) ? 6'(NBCAP) : cfg.bytes_per_glyph;
    pad_cnt = (nb_eff > h_eff) ? (nb_eff - h_eff) : 6'd0;
  end

  // Dot bit, shift and counter advance
  always_comb begin
    dot       = (pix_color[CMP_BITS-1:0] == cfg.dot_color[CMP_BITS-1:0]);
    shift_new = {shift_r[BYTE_W-2:0], dot};
    col_new   = column_r + COL_W'(1);
    row_new   = row_r + ROW_W'(1);
    row_end   = (col_new == '0) || ({1'b0, col_new} >= w_eff);
    glyph_end = (row_new == '0) || ({1'b0, row_new} >= h_eff);
  end

  // Next state
  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    shift_nxt  = shift_r;
    if (pix_fire) begin
      if (row_end) begin
        column_nxt = '0;
        shift_nxt  = '0;
        row_nxt    = glyph_end ? '0 : row_new;
      end else begin
        column_nxt = col_new;
        shift_nxt  = shift_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      shift_r  <= '0;
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      shift_r  <= shift_nxt;
    end
  end

  // Row result for the output stage
  always_comb begin
    res.valid = pix_fire && row_end;
    res.data  = finish_byte(shift_new, cfg);
    res.last  = glyph_end && (pad_cnt == 6'd0);
    res.pad   = glyph_end ? pad_cnt : 6'd0;
  end

endmodule

FILE: hw/rtl/grbp_out.sv
// Output register, skid slot and padding sequencer of the glyph row bit packer.
// Depends on grbp_pkg; takes row_res_t from grbp_row and drives the result stream.
module grbp_out
  import grbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  row_res_t          res,
  output logic              take_ok,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_pad_r, out_pad_nxt;
  logic              out_last_r, out_last_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [BYTE_W-1:0] skid_data_r, skid_data_nxt;
  logic              skid_last_r, skid_last_nxt;
  logic [5:0]        pad_left_r, pad_left_nxt;
  logic              slot_free;
  logic [BYTE_W-1:0] pad_byte;

  // New pixels only while the skid slot is empty and no padding is owed
  assign take_ok   = !skid_valid_r && (pad_left_r == 6'd0);
  assign slot_free = !out_valid_r || out_tready;
  assign pad_byte  = finish_byte('0, cfg);

  // Fill order for the output register: skid, fresh row byte, padding
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_pad_nxt    = out_pad_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_last_nxt  = skid_last_r;
    pad_left_nxt   = pad_left_r;
    if (slot_free) begin
      priority if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        out_pad_nxt    = 1'b0;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = 1'b0;
      end else if (res.valid) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res.data;
        out_pad_nxt   = 1'b0;
        out_last_nxt  = res.last;
      end else if (pad_left_r != 6'd0) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = pad_byte;
        out_pad_nxt   = 1'b1;
        out_last_nxt  = (pad_left_r == 6'd1);
        pad_left_nxt  = pad_left_r - 6'd1;
      end
    end else if (res.valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res.data;
      skid_last_nxt  = res.last;
    end
    // row results only arrive while no padding is owed
    if (res.valid) begin
      pad_left_nxt = res.pad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      pad_left_r   <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      pad_left_r   <= pad_left_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_pad_r   <= out_pad_nxt;
    out_last_r  <= out_last_nxt;
    skid_data_r <= skid_data_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_pad_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hw/rtl/grbp_chk.sv
// Port-level checker for the glyph row bit packer, bound to the top level.
// Depends on grbp_pkg for port widths.
module grbp_chk
  import grbp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata,
  input logic              out_tuser,
  input logic              out_tlast
);

  // A stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // Padding runs back to back until the glyph's last byte
  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser && !out_tlast |=> out_tvalid && out_tuser)
    else $error("padding run broken");

  // No pixel is taken while padding is still owed
  a_pad_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && !out_tlast |-> !in_tready)
    else $error("pixel accepted during padding");

  // Reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind glyph_row_bit_packer grbp_chk u_grbp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
